@@ hw/rtl/trd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP retransmit decision package
// Shared payload types, action and control codes, register map and reset
// values for the retransmit decision unit.
// ----------------------------------------------------------------------------
package trd_pkg;

  // Result action codes.
  typedef enum logic [1:0] {
    ACT_REFUSE   = 2'd0,
    ACT_ABORT    = 2'd1,
    ACT_SYN      = 2'd2,
    ACT_DATA     = 2'd3
  } trd_action_t;

  // Register indexes on the configuration port (byte address / 4).
  typedef enum logic [1:0] {
    REG_MAX_RETRIES     = 2'd0,
    REG_SYN_MAX_RETRIES = 2'd1,
    REG_MAX_TIMEOUT     = 2'd2
  } trd_reg_t;

  localparam int unsigned CfgAddrWidth = 4;

  // Bit positions in flag_bits.
  localparam int unsigned FlagSynSent  = 0;
  localparam int unsigned FlagFinSent  = 1;
  localparam int unsigned FlagPersist  = 2;
  localparam int unsigned FlagPeerSyn  = 3;
  localparam int unsigned FlagSynRcvd  = 4;

  // Bit positions in control_bits.
  localparam int unsigned CtrlSyn = 0;
  localparam int unsigned CtrlAck = 1;
  localparam int unsigned CtrlFin = 2;

  localparam logic [3:0]  MaxRetriesRst    = 4'd12;
  localparam logic [3:0]  SynMaxRetriesRst = 4'd4;
  localparam logic [31:0] MaxTimeoutRst    = 32'd60000;

  typedef struct packed {
    logic [31:0] snd_una;
    logic [31:0] snd_nxt;
    logic [31:0] initial_seq;
    logic [31:0] fin_seq;
    logic [4:0]  flag_bits;
    logic [3:0]  retry_count;
    logic [31:0] slow_start_threshold;
    logic [31:0] congestion_window;
    logic [31:0] send_window;
    logic [15:0] max_segment;
    logic [15:0] base_timeout;
  } trd_in_t;

  typedef struct packed {
    trd_action_t action;
    logic [2:0]  control_bits;
    logic [15:0] send_length;
    logic [31:0] timeout_value;
    logic [3:0]  new_retry_count;
    logic [31:0] new_threshold;
    logic [31:0] new_window;
  } trd_out_t;

  typedef struct packed {
    logic [3:0]  max_retries;
    logic [3:0]  syn_max_retries;
    logic [31:0] max_timeout;
  } trd_cfg_t;

endpackage

@@ hw/rtl/trd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP retransmit decision channel interfaces
// Valid/ready channels for timer events and for decision results.
// ----------------------------------------------------------------------------
interface trd_in_if import trd_pkg::*; ();
  logic    valid;
  logic    ready;
  trd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface trd_out_if import trd_pkg::*; ();
  logic     valid;
  logic     ready;
  trd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/tcp_retransmit_decision_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP retransmit decision unit
// Decides what to do on a retransmit-timer event for one connection snapshot.
// ----------------------------------------------------------------------------
// Each transfer on in_ch carries one retransmit-timer event with a snapshot
// of a connection's send variables, and yields exactly one result transfer on
// out_ch, in order. The event is captured in an input register, decided by
// one pass of combinational logic, and the result is held in an output
// register. A result is presented on out_ch once the output register has
// taken it from the input register, which holds it while the older result
// waits. The unit accepts one event per clock cycle, limited only by
// the two register stages: while a finished result waits for out_ch.ready it
// can still take one more event into the input register, and it stalls its
// input once both registers are full. The retry limits and timeout ceiling
// are written through the APB-style port (max_retries at 0x0,
// syn_max_retries at 0x4, max_timeout at 0x8) and should only be changed
// while no event is in flight.
// ----------------------------------------------------------------------------
module tcp_retransmit_decision_unit import trd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  trd_in_if.sink                  in_ch,
  trd_out_if.source               out_ch,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  trd_cfg_t cfg;
  trd_in_t  ev_r;
  trd_out_t res;
  trd_out_t res_r;
  logic     ev_valid_r;
  logic     ev_valid_nxt;
  logic     res_valid_r;
  logic     res_valid_nxt;
  logic     res_free;
  logic     ev_adv;
  logic     in_xfer;
  logic     out_xfer;

  trd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The output register can take a new result when it is empty or when its
  // current result is being transferred out in this cycle.
  assign res_free     = !res_valid_r || out_ch.ready;
  assign ev_adv       = ev_valid_r && res_free;
  assign in_ch.ready  = !ev_valid_r || res_free;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_xfer     = res_valid_r && out_ch.ready;

  assign ev_valid_nxt  = in_xfer ? 1'b1 : (ev_adv ? 1'b0 : ev_valid_r);
  assign res_valid_nxt = ev_adv ? 1'b1 : (out_xfer ? 1'b0 : res_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      ev_valid_r  <= ev_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ev_r <= in_ch.data;
    end
    if (ev_adv) begin
      res_r <= res;
    end
  end

  trd_decide u_decide (
    .ev  (ev_r),
    .cfg (cfg),
    .res (res)
  );

  assign out_ch.valid = res_valid_r;
  assign out_ch.data  = res_r;

  // An event waiting in the input register stays there until it can move on.
  a_ev_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_valid_r && !res_free) |=> ev_valid_r)
    else $error("event dropped from input register while output was blocked");

  // Refused and aborted events carry no segment and no timer.
  a_no_send: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && (res_r.action == ACT_REFUSE || res_r.action == ACT_ABORT)) |->
    (res_r.send_length == 16'd0 && res_r.timeout_value == 32'd0
     && res_r.control_bits == 3'd0))
    else $error("refused or aborted result carries send data");

  // A SYN resend is one octet with SYN set and never FIN.
  a_syn_form: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.action == ACT_SYN) |->
    (res_r.send_length == 16'd1 && res_r.control_bits[CtrlSyn]
     && !res_r.control_bits[CtrlFin]))
    else $error("malformed SYN resend");

  // A data resend floors the threshold at the new window (one segment).
  a_data_thr: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.action == ACT_DATA) |->
    (res_r.new_threshold >= res_r.new_window && res_r.control_bits[CtrlAck]
     && {16'd0, res_r.send_length} <= res_r.new_window))
    else $error("data resend threshold, window or length inconsistent");

endmodule

@@ hw/rtl/trd_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP retransmit decision register file
// APB-style configuration registers: retry limits and timeout ceiling.
// ----------------------------------------------------------------------------
module trd_cfg import trd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output trd_cfg_t                cfg
);

  logic [3:0]  max_retries_r;
  logic [3:0]  syn_max_retries_r;
  logic [31:0] max_timeout_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r     <= MaxRetriesRst;
      syn_max_retries_r <= SynMaxRetriesRst;
      max_timeout_r     <= MaxTimeoutRst;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MAX_RETRIES:     max_retries_r     <= pwdata[3:0];
        REG_SYN_MAX_RETRIES: syn_max_retries_r <= pwdata[3:0];
        REG_MAX_TIMEOUT:     max_timeout_r     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_RETRIES:     prdata = {28'd0, max_retries_r};
      REG_SYN_MAX_RETRIES: prdata = {28'd0, syn_max_retries_r};
      REG_MAX_TIMEOUT:     prdata = max_timeout_r;
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg.max_retries     = max_retries_r;
  assign cfg.syn_max_retries = syn_max_retries_r;
  assign cfg.max_timeout     = max_timeout_r;

endmodule

@@ hw/rtl/trd_decide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP retransmit decision logic
// Combinational decision for one timer event: refuse, abort, SYN resend or
// data resend, with backed-off timeout and congestion updates.
// ----------------------------------------------------------------------------
module trd_decide import trd_pkg::*; (
  input  trd_in_t  ev,
  input  trd_cfg_t cfg,
  output trd_out_t res
);

  // Sequence order: a is before b when the wrapped difference is negative.
  function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  logic        refuse;
  logic [4:0]  next_cnt;
  logic [3:0]  limit;
  logic        abort;
  logic [30:0] shifted;
  logic [31:0] tmo;
  logic        syn_resend;
  logic [31:0] pending;
  logic        fin_in_range;
  logic        pend_gt_mss;
  logic [31:0] thr_start;
  logic [31:0] thr_half;
  logic [31:0] thr_new;
  logic [31:0] mss_ext;

  assign refuse   = !seq_before(ev.snd_una, ev.snd_nxt) || ev.flag_bits[FlagPersist];
  assign next_cnt = {1'b0, ev.retry_count} + 5'd1;
  assign limit    = ev.flag_bits[FlagSynRcvd] ? cfg.syn_max_retries : cfg.max_retries;
  assign abort    = next_cnt > {1'b0, limit};

  // Without abort the incremented count is at most fifteen, so the shifted
  // base fits in 31 bits.
  assign shifted = {15'd0, ev.base_timeout} << next_cnt[3:0];
  assign tmo     = ({1'b0, shifted} > cfg.max_timeout) ? cfg.max_timeout
                                                       : {1'b0, shifted};

  assign syn_resend = ev.flag_bits[FlagSynSent] && (ev.snd_una == ev.initial_seq);

  assign pending      = ev.snd_nxt - ev.snd_una;
  assign mss_ext      = {16'd0, ev.max_segment};
  assign pend_gt_mss  = pending > mss_ext;
  assign fin_in_range = ev.flag_bits[FlagFinSent] && !seq_before(ev.fin_seq, ev.snd_una)
                        && seq_before(ev.fin_seq, ev.snd_nxt);

  assign thr_start = (ev.retry_count == 4'd0) ? ev.congestion_window
                                              : ev.slow_start_threshold;
  assign thr_half  = (ev.send_window < thr_start) ? {1'b0, ev.send_window[31:1]}
                                                  : {1'b0, thr_start[31:1]};
  assign thr_new   = (thr_half < mss_ext) ? mss_ext : thr_half;

  always_comb begin
    res.action          = ACT_REFUSE;
    res.control_bits    = 3'd0;
    res.send_length     = 16'd0;
    res.timeout_value   = 32'd0;
    res.new_retry_count = ev.retry_count;
    res.new_threshold   = ev.slow_start_threshold;
    res.new_window      = ev.congestion_window;
    if (!refuse) begin
      res.new_retry_count = next_cnt[4] ? 4'hF : next_cnt[3:0];
      if (abort) begin
        res.action = ACT_ABORT;
      end else if (syn_resend) begin
        res.action                = ACT_SYN;
        res.timeout_value         = tmo;
        res.send_length           = 16'd1;
        res.control_bits[CtrlSyn] = 1'b1;
        res.control_bits[CtrlAck] = ev.flag_bits[FlagPeerSyn];
      end else begin
        res.action                = ACT_DATA;
        res.timeout_value         = tmo;
        res.send_length           = pend_gt_mss ? ev.max_segment : pending[15:0];
        res.control_bits[CtrlAck] = 1'b1;
        res.control_bits[CtrlFin] = fin_in_range && !pend_gt_mss;
        res.new_threshold         = thr_new;
        res.new_window            = mss_ext;
      end
    end
  end

endmodule
